[hw/rtl/bbde_pkg.sv]
// Shared types, widths and arithmetic helpers for the Bernstein basis evaluator.
package bbde_pkg;

	localparam int MAX_POINTS  = 16;
	localparam int T_FRAC_BITS = 16;
	localparam int TW          = T_FRAC_BITS + 1;
	localparam int EXP_W       = $clog2(MAX_POINTS);
	localparam int CNT_W       = EXP_W + 1;
	localparam int C_W         = 13;
	localparam int F_W         = 8;
	localparam int CF_W        = C_W + F_W;
	localparam int TERM_W      = CF_W + TW;
	localparam int SUM_W       = TERM_W + 1;
	localparam int DIFF_W      = SUM_W + 1;
	localparam int RES_W       = 48;
	localparam int POW_STAGES  = MAX_POINTS - 1;
	localparam int NTERM       = 3;

	localparam logic [TW-1:0] T_ONE = TW'(1) << T_FRAC_BITS;
	localparam logic [2*TW-1:0] T_HALF = (2*TW)'(1) << (T_FRAC_BITS - 1);

	localparam logic [CNT_W-1:0] RESET_COUNT = CNT_W'(4);

	// Term slots: two positive terms and one negative term.
	localparam int TERM_POS1 = 0;
	localparam int TERM_POS2 = 1;
	localparam int TERM_NEG  = 2;

	typedef enum logic [1:0] {
		OP_VALUE  = 2'd0,
		OP_DERIV1 = 2'd1,
		OP_DERIV2 = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

	typedef logic [MAX_POINTS-1:0][C_W-1:0] row_t;

	// Binomial row for the reset degree of three: 1, 3, 3, 1, zero beyond.
	localparam row_t RESET_ROW = row_t'({C_W'(1), C_W'(3), C_W'(3), C_W'(1)});

	// Row that starts a Pascal rebuild: a single one in entry zero.
	localparam row_t START_ROW = row_t'(1);

	typedef struct packed {
		logic                           err;
		logic [TW-1:0]                  t;
		logic [TW-1:0]                  u;
		logic [TW-1:0]                  pt;
		logic [TW-1:0]                  pu;
		logic [NTERM-1:0][EXP_W-1:0]    ea;
		logic [NTERM-1:0][EXP_W-1:0]    eb;
		logic [NTERM-1:0][TW-1:0]       ct;
		logic [NTERM-1:0][TW-1:0]       cu;
		logic [C_W-1:0]                 coef;
		logic [NTERM-1:0][F_W-1:0]      fac;
	} pipe_t;

	// Fixed-point product rounded half up back to T_FRAC_BITS fraction bits.
	function automatic logic [TW-1:0] fx_mul(input logic [TW-1:0] a, input logic [TW-1:0] b);
		logic [2*TW-1:0] p;
		p = ((2*TW)'(a) * (2*TW)'(b)) + T_HALF;
		return p[T_FRAC_BITS+TW-1:T_FRAC_BITS];
	endfunction

endpackage

[hw/rtl/bbde_binom.sv]
// Point count register and Pascal-triangle rebuild of the binomial row.
module bbde_binom import bbde_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [4:0]          cfg_data,
	output row_t                row,
	output logic [EXP_W-1:0]    degree,
	output logic                rebuilding
);

	logic [4:0]       count_q;
	logic [EXP_W-1:0] iter_q;
	row_t             row_q;
	logic [4:0]       new_eff;
	logic [4:0]       cur_eff;

	function automatic logic [4:0] eff_count(input logic [4:0] n);
		logic [4:0] r;
		r = n;
		if (n == 5'd0) r = 5'd1;
		if ({27'd0, n} > MAX_POINTS) r = 5'(MAX_POINTS);
		return r;
	endfunction

	assign new_eff    = eff_count(cfg_data);
	assign cur_eff    = eff_count(count_q);
	assign degree     = EXP_W'(cur_eff - 5'd1);
	assign rebuilding = (iter_q != '0);
	assign cfg_ready  = !rebuilding;
	assign row        = row_q;

	// Each pass adds every entry to its right neighbor; d passes give row d.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 5'(RESET_COUNT);
			iter_q  <= '0;
			row_q   <= RESET_ROW;
		end else if (cfg_valid && cfg_ready) begin
			count_q  <= cfg_data;
			iter_q   <= EXP_W'(new_eff - 5'd1);
			row_q    <= START_ROW;
		end else if (rebuilding) begin
			iter_q <= iter_q - EXP_W'(1);
			for (int m = 1; m < MAX_POINTS; m++) begin
				row_q[m] <= row_q[m] + row_q[m-1];
			end
		end
	end

endmodule

[hw/rtl/bbde_front.sv]
// First pipeline stage: clamps t, reads the coefficient and picks exponents and factors.
module bbde_front import bbde_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic [1:0]          opcode,
	input  logic [3:0]          basis_index,
	input  logic [16:0]         param_t,
	input  row_t                row,
	input  logic [EXP_W-1:0]    degree,
	output logic                valid_s1,
	output pipe_t               data_s1
);

	pipe_t            nxt;
	logic [TW-1:0]    tsat;
	logic [EXP_W-1:0] i;
	logic [EXP_W-1:0] j;
	logic [F_W-1:0]   iw;
	logic [F_W-1:0]   jw;
	op_t              op;

	always_comb begin
		op   = op_t'(opcode);
		i    = EXP_W'(basis_index);
		tsat = (param_t > 17'(T_ONE)) ? T_ONE : TW'(param_t);
		j    = degree - i;
		iw   = F_W'(i);
		jw   = F_W'(j);
		nxt       = '0;
		nxt.err   = (i > degree);
		nxt.t     = tsat;
		nxt.u     = T_ONE - tsat;
		nxt.pt    = T_ONE;
		nxt.pu    = T_ONE;
		nxt.coef  = row[i];
		if (!nxt.err) begin
			unique case (op)
				OP_VALUE: begin
					nxt.ea[TERM_POS1]  = i;
					nxt.eb[TERM_POS1]  = j;
					nxt.fac[TERM_POS1] = F_W'(1);
				end
				OP_DERIV1: begin
					if (i >= EXP_W'(1)) begin
						nxt.ea[TERM_POS1]  = i - EXP_W'(1);
						nxt.eb[TERM_POS1]  = j;
						nxt.fac[TERM_POS1] = iw;
					end
					if (j >= EXP_W'(1)) begin
						nxt.ea[TERM_NEG]  = i;
						nxt.eb[TERM_NEG]  = j - EXP_W'(1);
						nxt.fac[TERM_NEG] = jw;
					end
				end
				OP_DERIV2: begin
					if (i >= EXP_W'(2)) begin
						nxt.ea[TERM_POS1]  = i - EXP_W'(2);
						nxt.eb[TERM_POS1]  = j;
						nxt.fac[TERM_POS1] = F_W'(iw * (iw - F_W'(1)));
					end
					if (j >= EXP_W'(2)) begin
						nxt.ea[TERM_POS2]  = i;
						nxt.eb[TERM_POS2]  = j - EXP_W'(2);
						nxt.fac[TERM_POS2] = F_W'(jw * (jw - F_W'(1)));
					end
					if (i >= EXP_W'(1) && j >= EXP_W'(1)) begin
						nxt.ea[TERM_NEG]  = i - EXP_W'(1);
						nxt.eb[TERM_NEG]  = j - EXP_W'(1);
						nxt.fac[TERM_NEG] = F_W'((iw * jw) << 1);
					end
				end
				OP_NONE: begin
				end
				default: begin
				end
			endcase
		end
		// Exponent zero is exactly one, captured here.
		for (int m = 0; m < NTERM; m++) begin
			nxt.ct[m] = T_ONE;
			nxt.cu[m] = T_ONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		data_s1 <= nxt;
	end

endmodule

[hw/rtl/bbde_pow_stage.sv]
// One power stage: raises the running powers of t and 1-t by one step and captures matches.
module bbde_pow_stage import bbde_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [EXP_W-1:0]    stage_exp,
	input  logic                in_valid,
	input  pipe_t               in_data,
	output logic                out_valid,
	output pipe_t               out_data
);

	pipe_t nxt;

	always_comb begin
		nxt    = in_data;
		nxt.pt = fx_mul(in_data.pt, in_data.t);
		nxt.pu = fx_mul(in_data.pu, in_data.u);
		for (int m = 0; m < NTERM; m++) begin
			if (in_data.ea[m] == stage_exp) nxt.ct[m] = nxt.pt;
			if (in_data.eb[m] == stage_exp) nxt.cu[m] = nxt.pu;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else begin
			out_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		out_data <= nxt;
	end

endmodule

[hw/rtl/bbde_back.sv]
// Back end: power products, scaling by coefficient and factor, and the signed combine.
module bbde_back import bbde_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  pipe_t               in_data,
	output logic                out_valid,
	output logic [RES_W-1:0]    result,
	output logic                err
);

	logic                          valid_s1, valid_s2;
	logic [NTERM-1:0][TW-1:0]      pp_s1;
	logic [NTERM-1:0][CF_W-1:0]    cf_s1;
	logic                          err_s1, err_s2;
	logic [NTERM-1:0][TERM_W-1:0]  term_s2;
	logic [SUM_W-1:0]              pos;
	logic [DIFF_W-1:0]             diff;

	// Terms stay far below the 48-bit limit, so the difference is only sign-extended and no saturation is needed.
	assign pos  = SUM_W'(term_s2[TERM_POS1]) + SUM_W'(term_s2[TERM_POS2]);
	assign diff = DIFF_W'(pos) - DIFF_W'(term_s2[TERM_NEG]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			valid_s2  <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			valid_s1  <= in_valid;
			valid_s2  <= valid_s1;
			out_valid <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		err_s1 <= in_data.err;
		err_s2 <= err_s1;
		err    <= err_s2;
		for (int m = 0; m < NTERM; m++) begin
			pp_s1[m]   <= fx_mul(in_data.ct[m], in_data.cu[m]);
			cf_s1[m]   <= CF_W'(in_data.coef) * CF_W'(in_data.fac[m]);
			term_s2[m] <= TERM_W'(cf_s1[m]) * TERM_W'(pp_s1[m]);
		end
		result <= {{(RES_W-DIFF_W){diff[DIFF_W-1]}}, diff};
	end

endmodule

[hw/rtl/bernstein_basis_derivative_eval_top.sv]
// Top level of the Bernstein basis value and derivative evaluator.
// Usage:
// A request is taken at a rising edge where start is high and busy is low. It carries
// opcode (value, first or second derivative), basis_index and param_t (16 fraction bits).
// The result appears on basis_result and index_error for exactly one cycle, marked by
// result_valid. The receiver cannot stall, so nothing holds the pipeline: one request
// can be taken every cycle while busy is low.
// The pipeline is the chain of power stages, one per possible exponent (15 for
// 16 points), plus one decode stage and three stages of products and combine.
// The configuration channel (cfg_valid, cfg_ready, cfg_data) writes point_count.
// After a write the binomial row is rebuilt by Pascal passes, one per degree step,
// and busy stays high and cfg_ready low until the passes end. The new degree is
// point_count minus one after point_count is clamped into 1..16.
// Reset sets point_count to four with the degree-three row loaded at once, and empties
// the pipeline, dropping requests in flight; else none is lost or repeated, and results
// keep request order. An index above the degree gives a zero result with index_error set.
module bernstein_basis_derivative_eval_top import bbde_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic [1:0]          opcode,
	input  logic [3:0]          basis_index,
	input  logic [16:0]         param_t,
	output logic                result_valid,
	output logic [RES_W-1:0]    basis_result,
	output logic                index_error,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [4:0]          cfg_data
);

	row_t             row;
	logic [EXP_W-1:0] degree;
	logic             rebuilding;

	// Stage zero of this chain is the decode register; the rest are power stages.
	logic  [POW_STAGES:0] valid_st;
	pipe_t [POW_STAGES:0] data_st;

	assign busy = rebuilding;

	bbde_binom u_binom (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data),
		.row        (row),
		.degree     (degree),
		.rebuilding (rebuilding)
	);

	bbde_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (start && !busy),
		.opcode      (opcode),
		.basis_index (basis_index),
		.param_t     (param_t),
		.row         (row),
		.degree      (degree),
		.valid_s1    (valid_st[0]),
		.data_s1     (data_st[0])
	);

	// Stage k leaves t^k and (1-t)^k, each step rounded, and captures the exponents asked for.
	for (genvar k = 1; k <= POW_STAGES; k++) begin : g_pow
		bbde_pow_stage u_pow (
			.clk       (clk),
			.arst_n    (arst_n),
			.stage_exp (EXP_W'(k)),
			.in_valid  (valid_st[k-1]),
			.in_data   (data_st[k-1]),
			.out_valid (valid_st[k]),
			.out_data  (data_st[k])
		);
	end

	bbde_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (valid_st[POW_STAGES]),
		.in_data   (data_st[POW_STAGES]),
		.out_valid (result_valid),
		.result    (basis_result),
		.err       (index_error)
	);

endmodule
